// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers for the activation function unit checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is asserted
`define AFU_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("afu_checker: property failed");

// plain invariant, checked at every clock edge out of reset
`define AFU_ASSERT_ALWAYS(label, expr) \
  `AFU_ASSERT(label, (expr))

`endif

// ----- hw/rtl/afu_pkg.sv -----
// ----------------------------------------------------------------------------
// afu_pkg
// shared types, constants and the logistic sample table of the activation
// function unit
// ----------------------------------------------------------------------------
package afu_pkg;

  localparam int VALUE_W     = 16;
  localparam int FRAC_BITS   = 12;
  localparam int LUT_ENTRIES = 256;
  localparam int LUT_AW      = $clog2(LUT_ENTRIES);
  localparam int MODE_W      = 3;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int SIG_W       = 32;
  localparam int WIDE_W      = 34;

  localparam int ONE_FX = 1 << FRAC_BITS;
  localparam int C001   = ((1 << FRAC_BITS) + 50) / 100;
  localparam int C099   = ((99 << FRAC_BITS) + 50) / 100;
  localparam int C199   = ((199 << FRAC_BITS) + 50) / 100;

  localparam longint unsigned Q31_ONE = 64'h0000_0000_8000_0000;

  typedef enum logic [MODE_W-1:0] {
    MODE_RAMP  = 3'd0,
    MODE_RELU  = 3'd1,
    MODE_BLOG  = 3'd2,
    MODE_ULOG  = 3'd3,
    MODE_BSTEP = 3'd4,
    MODE_USTEP = 3'd5
  } act_mode_e;

  localparam logic KIND_ACT   = 1'b0;
  localparam logic KIND_DERIV = 1'b1;

  localparam logic [APB_AW-3:0] REG_ACT_MODE = '0;

  typedef struct packed {
    logic                      kind;
    logic signed [VALUE_W-1:0] value;
  } afu_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result;
    logic                      saturated;
  } afu_result_t;

  typedef logic [LUT_ENTRIES-1:0][SIG_W-1:0] sig_tab_t;

  // unsigned quotient by shift and subtract, used while building the table
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    int              b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-f, f and result in Q31, f in [0, 1], truncated taylor series
  function automatic longint exp_neg_q31(input longint unsigned f);
    longint          sum;
    longint unsigned term;
    int              k;
    sum  = longint'(Q31_ONE);
    term = Q31_ONE;
    for (k = 1; k <= 24; k++) begin
      term = udiv64((term * f) >> 31, longint'(unsigned'(k)));
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return (sum < 0) ? 64'sd0 : sum;
  endfunction

  // samples of the unipolar logistic over [0, 8) in Q31
  function automatic sig_tab_t build_sig_tab();
    sig_tab_t        tab;
    longint unsigned e1;
    longint unsigned t;
    longint unsigned e;
    longint unsigned whole;
    int              i;
    longint unsigned j;
    e1 = longint'(exp_neg_q31(Q31_ONE));
    for (i = 0; i < LUT_ENTRIES; i++) begin
      t     = (longint'(unsigned'(i)) << 34) / LUT_ENTRIES;
      whole = t >> 31;
      e     = exp_neg_q31(t & (Q31_ONE - 1));
      for (j = 0; j < whole; j++) begin
        e = (e * e1) >> 31;
      end
      tab[i] = SIG_W'(udiv64(64'h4000_0000_0000_0000, Q31_ONE + e));
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

// ----- hw/rtl/afu_regs.sv -----
// ----------------------------------------------------------------------------
// afu_regs
// apb configuration register holding the activation mode
// ----------------------------------------------------------------------------
module afu_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [afu_pkg::APB_AW-1:0] paddr,
  input  logic [afu_pkg::APB_DW-1:0] pwdata,
  output logic [afu_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [afu_pkg::MODE_W-1:0] act_mode_o
);
  import afu_pkg::*;

  logic [MODE_W-1:0]   mode_q;
  logic [MODE_W-1:0]   mode_d;
  logic [APB_AW-3:0]   reg_idx;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_ACT_MODE);

  always_comb begin
    mode_d = mode_q;
    if (wr_en) begin
      mode_d = pwdata[MODE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RAMP;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACT_MODE: begin
        prdata = APB_DW'(mode_q);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign act_mode_o = mode_q;

endmodule

// ----- hw/rtl/afu_datapath.sv -----
// ----------------------------------------------------------------------------
// afu_datapath
// single pass evaluation of the selected activation or its derivative,
// with saturation to the q4.12 range
// ----------------------------------------------------------------------------
module afu_datapath (
  input  logic [afu_pkg::MODE_W-1:0] mode_i,
  input  afu_pkg::afu_item_t         item_i,
  output afu_pkg::afu_result_t       res_o
);
  import afu_pkg::*;

  localparam int IDXP_W = VALUE_W + LUT_AW + 2;
  localparam int IDXF_W = IDXP_W - FRAC_BITS - 3;
  localparam int SH_LOG = 31 - FRAC_BITS;

  localparam logic [IDXP_W-1:0] IDX_RND  = IDXP_W'(1 << (FRAC_BITS + 2));
  localparam logic [IDXF_W-1:0] IDX_LIM  = IDXF_W'(LUT_ENTRIES);
  localparam logic [SIG_W-1:0]  SIG_ONE  = SIG_W'(Q31_ONE);

  localparam logic signed [VALUE_W-1:0] C001_S = VALUE_W'(C001);

  localparam logic signed [WIDE_W-1:0] ONE_W   = WIDE_W'(ONE_FX);
  localparam logic signed [WIDE_W-1:0] C001_W  = WIDE_W'(C001);
  localparam logic signed [WIDE_W-1:0] C099_W  = WIDE_W'(C099);
  localparam logic signed [WIDE_W-1:0] C199_W  = WIDE_W'(C199);
  localparam logic signed [WIDE_W-1:0] Q31_W   = WIDE_W'(Q31_ONE);
  localparam logic signed [WIDE_W-1:0] RND_LOG = WIDE_W'(1 << (SH_LOG - 1));
  localparam logic signed [WIDE_W-1:0] RND_F   = WIDE_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [WIDE_W-1:0] ONE_SQ  = WIDE_W'(1 << (2 * FRAC_BITS));
  localparam logic signed [WIDE_W-1:0] MAX_W   = WIDE_W'((1 << (VALUE_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] MIN_W   = -WIDE_W'(1 << (VALUE_W - 1));

  logic signed [VALUE_W-1:0] x;
  logic [VALUE_W-1:0]        ax;
  logic                      x_neg;
  logic                      x_zero;
  logic                      x_pos;
  logic                      deriv;
  logic [IDXP_W-1:0]         idx_prod;
  logic [IDXF_W-1:0]         idx_full;
  logic [SIG_W-1:0]          sig_s;
  logic [SIG_W-1:0]          p_s;
  logic signed [31:0]        sq;
  logic signed [31:0]        lin;
  logic signed [WIDE_W-1:0]  x_w;
  logic signed [WIDE_W-1:0]  p_w;
  logic signed [WIDE_W-1:0]  sq_w;
  logic signed [WIDE_W-1:0]  lin_w;
  logic signed [WIDE_W-1:0]  uni_w;
  logic signed [WIDE_W-1:0]  bi_w;
  logic signed [WIDE_W-1:0]  relu_w;
  logic signed [WIDE_W-1:0]  bd_w;
  logic signed [WIDE_W-1:0]  ud_w;
  logic signed [WIDE_W-1:0]  r_w;

  assign x      = item_i.value;
  assign deriv  = (item_i.kind == KIND_DERIV);
  assign x_neg  = x[VALUE_W-1];
  assign x_zero = (x == '0);
  assign x_pos  = !x_neg && !x_zero;
  assign ax     = x_neg ? VALUE_W'(-x) : x;

  // logistic table lookup, clamps to one at and beyond the table end
  assign idx_prod = IDXP_W'(ax) * IDXP_W'(LUT_ENTRIES) + IDX_RND;
  assign idx_full = idx_prod[IDXP_W-1:FRAC_BITS+3];
  assign sig_s    = (idx_full >= IDX_LIM) ? SIG_ONE : SIG_TAB[idx_full[LUT_AW-1:0]];
  assign p_s      = x_neg ? (SIG_ONE - sig_s) : sig_s;
  assign p_w      = WIDE_W'(p_s);

  assign uni_w = (p_w + RND_LOG) >>> SH_LOG;
  assign bi_w  = ((p_w <<< 1) - Q31_W + RND_LOG) >>> SH_LOG;

  assign sq    = x * x;
  assign lin   = x * C001_S;
  assign x_w   = WIDE_W'(x);
  assign sq_w  = WIDE_W'(sq);
  assign lin_w = WIDE_W'(lin);

  assign relu_w = (lin_w + RND_F) >>> FRAC_BITS;
  assign bd_w   = (ONE_SQ - sq_w + ONE_W) >>> (FRAC_BITS + 1);
  assign ud_w   = ((x_w <<< FRAC_BITS) - sq_w + RND_F) >>> FRAC_BITS;

  always_comb begin
    case (act_mode_e'(mode_i))
      MODE_RELU: begin
        if (deriv) begin
          r_w = x_pos ? ONE_W : C001_W;
        end else begin
          r_w = x_pos ? x_w : relu_w;
        end
      end
      MODE_BLOG: begin
        r_w = deriv ? bd_w : bi_w;
      end
      MODE_ULOG: begin
        r_w = deriv ? ud_w : uni_w;
      end
      MODE_BSTEP: begin
        if (deriv) begin
          r_w = x_zero ? C199_W : C001_W;
        end else begin
          r_w = x_neg ? -C099_W : (x_pos ? C099_W : '0);
        end
      end
      MODE_USTEP: begin
        if (deriv) begin
          r_w = x_zero ? C099_W : C001_W;
        end else begin
          r_w = x_neg ? C001_W : (x_pos ? C099_W : '0);
        end
      end
      default: begin
        r_w = deriv ? ONE_W : x_w;
      end
    endcase
  end

  always_comb begin
    if (r_w > MAX_W) begin
      res_o.result    = {1'b0, {(VALUE_W-1){1'b1}}};
      res_o.saturated = 1'b1;
    end else if (r_w < MIN_W) begin
      res_o.result    = {1'b1, {(VALUE_W-1){1'b0}}};
      res_o.saturated = 1'b1;
    end else begin
      res_o.result    = r_w[VALUE_W-1:0];
      res_o.saturated = 1'b0;
    end
  end

endmodule

// ----- hw/rtl/activation_function_unit.sv -----
// ----------------------------------------------------------------------------
// activation_function_unit
// applies a configurable neural activation function, or its derivative,
// to a stream of signed q4.12 operands
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_ready_o carry kind_i (0 activation,
// 1 derivative) and value_i. output channel: out_valid_o / out_ready_i carry
// result_o and saturated_o, one result per accepted input, in order.
// the mode register (ramp, leaky relu, bipolar and unipolar logistic,
// bipolar and unipolar step) sits at apb address 0; it must be written only
// while no transaction is in flight, and the block itself does not enforce this.
// an operand lands in the input register, the function is evaluated in one
// pass (two 16x16 multiplies and one lookup into a 256-entry logistic table)
// and the result is written to the result register.
// throughput is one transaction per cycle while out_ready_i stays high.
// when the receiver stalls, the result register holds its transaction and
// the input register can still take one more before in_ready_o drops.
// reset clears both valid flags and sets the mode to ramp; the logistic
// table is constant and needs no fill.
// ----------------------------------------------------------------------------
module activation_function_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [afu_pkg::APB_AW-1:0]        paddr,
  input  logic [afu_pkg::APB_DW-1:0]        pwdata,
  output logic [afu_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic signed [afu_pkg::VALUE_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [afu_pkg::VALUE_W-1:0] result_o,
  output logic                              saturated_o
);
  import afu_pkg::*;

  logic [MODE_W-1:0] act_mode;
  logic              in_accept;
  logic              res_load;
  logic              item_vld_q;
  logic              item_vld_d;
  logic              out_vld_q;
  logic              out_vld_d;
  afu_item_t         item_q;
  afu_result_t       res_d;
  afu_result_t       res_q;

  afu_regs u_afu_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .act_mode_o (act_mode)
  );

  afu_datapath u_afu_datapath (
    .mode_i (act_mode),
    .item_i (item_q),
    .res_o  (res_d)
  );

  assign res_load   = item_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || res_load;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    item_vld_d = item_vld_q;
    if (in_accept) begin
      item_vld_d = 1'b1;
    end else if (res_load) begin
      item_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (res_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.kind  <= kind_i;
      item_q.value <= value_i;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = res_q.result;
  assign saturated_o = res_q.saturated;

endmodule

// ----- hw/rtl/afu_checker.sv -----
// ----------------------------------------------------------------------------
// afu_props
// port level checks of the activation function unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module afu_props (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [afu_pkg::APB_AW-1:0]         paddr,
  input logic [afu_pkg::APB_DW-1:0]         pwdata,
  input logic [afu_pkg::APB_DW-1:0]         prdata,
  input logic                               pready,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [afu_pkg::VALUE_W-1:0] result_o,
  input logic                               saturated_o
);
  import afu_pkg::*;

  logic cfg_wr;
  logic mode_wr;
  logic mode_rd;
  logic at_limit;

  assign cfg_wr   = psel && penable && pwrite && pready;
  assign mode_wr  = cfg_wr && (paddr[APB_AW-1:2] == REG_ACT_MODE);
  assign mode_rd  = (paddr[APB_AW-1:2] == REG_ACT_MODE);
  assign at_limit = (result_o == {1'b0, {(VALUE_W-1){1'b1}}}) ||
                    (result_o == {1'b1, {(VALUE_W-1){1'b0}}});

  // stalled transaction stays on the output
  `AFU_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)
  `AFU_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(result_o))

  // a saturated result sits on one of the range limits
  `AFU_ASSERT(a_sat_limit, out_valid_o && saturated_o |-> at_limit)

  // mode register reads back what was written
  `AFU_ASSERT(a_mode_readback, mode_wr ##1 mode_rd |-> prdata[MODE_W-1:0] == $past(pwdata[MODE_W-1:0]))

  `AFU_ASSERT_ALWAYS(a_prdata_upper, prdata[APB_DW-1:MODE_W] == '0)

endmodule

bind activation_function_unit afu_props u_afu_props (.*);

// ----- dv/afu_checker.sv -----
// ----------------------------------------------------------------------------
// afu_checker
// Watches the configuration port and both streaming channels of the
// activation function unit. It keeps its own copy of the mode register and
// its own logistic sample table. For every accepted input transaction it
// computes the expected result and saturation flag, and it compares each
// result transaction, field by field, with the oldest expectation.
// ----------------------------------------------------------------------------
module afu_checker
  import afu_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [APB_AW-1:0]           paddr,
  input  logic [APB_DW-1:0]           pwdata,
  input  logic                        pready,
  input  logic                        in_valid_i,
  input  logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic signed [VALUE_W-1:0]   value_i,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic signed [VALUE_W-1:0]   result_o,
  input  logic                        saturated_o,
  output int                          outstanding_o,
  output int                          mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_AW-1:0] MODE_ADDR = {REG_ACT_MODE, 2'b00};
  localparam longint unsigned   Q31U      = 64'd1 << 31;
  localparam longint            Q31       = longint'(Q31U);
  localparam longint            UNIT      = longint'(1) << FRAC_BITS;
  localparam longint            LEAK      = ((longint'(1) << FRAC_BITS) + 50) / 100;
  localparam longint            NEAR_ONE  = ((longint'(99) << FRAC_BITS) + 50) / 100;
  localparam longint            NEAR_TWO  = ((longint'(199) << FRAC_BITS) + 50) / 100;
  localparam longint            VAL_MAX   = (longint'(1) << (VALUE_W - 1)) - 1;
  localparam longint            VAL_MIN   = -(longint'(1) << (VALUE_W - 1));

  longint unsigned   sig_samples [LUT_ENTRIES];
  logic [MODE_W-1:0] mode;
  afu_result_t       expected_results [$];
  int                mismatches;

  // e^-f with f and the result in q31, f in [0, 1]
  function automatic longint unsigned exp_neg(input longint unsigned f);
    longint unsigned term;
    longint          acc;
    longint unsigned k;
    term = Q31U;
    acc  = Q31;
    for (k = 1; k <= 24; k++) begin
      term = ((term * f) >> 31) / k;
      if (k[0]) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    return (acc < 0) ? 64'd0 : longint'(acc);
  endfunction

  function automatic void fill_samples();
    longint unsigned e1;
    longint unsigned pos;
    longint unsigned e;
    longint unsigned n;
    e1 = exp_neg(Q31U);
    for (int i = 0; i < LUT_ENTRIES; i++) begin
      pos = (longint'(i) << 34) / LUT_ENTRIES;
      e   = exp_neg(pos & (Q31U - 1));
      for (n = 0; n < (pos >> 31); n++) begin
        e = (e * e1) >> 31;
      end
      sig_samples[i] = (64'd1 << 62) / (Q31U + e);
    end
  endfunction

  initial fill_samples();

  // round to nearest, ties upward
  function automatic longint round_down_by(input longint p, input int sh);
    return (p + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // unipolar logistic in q31
  function automatic longint logistic(input longint x);
    longint unsigned mag;
    longint unsigned idx;
    longint          s;
    mag = (x < 0) ? longint'(-x) : longint'(x);
    idx = (mag * LUT_ENTRIES + (64'd1 << (FRAC_BITS + 2))) >> (FRAC_BITS + 3);
    s   = (idx >= LUT_ENTRIES) ? Q31 : longint'(sig_samples[idx]);
    return (x < 0) ? Q31 - s : s;
  endfunction

  function automatic afu_result_t activate(input logic [MODE_W-1:0] m, input logic kind,
                                           input logic signed [VALUE_W-1:0] v);
    longint      x;
    longint      r;
    afu_result_t res;
    x = v;
    case (m)
      MODE_RELU: begin
        if (kind == KIND_DERIV) begin
          r = (x > 0) ? UNIT : LEAK;
        end else begin
          r = (x > 0) ? x : round_down_by(x * LEAK, FRAC_BITS);
        end
      end
      MODE_BLOG: begin
        if (kind == KIND_DERIV) begin
          r = round_down_by((UNIT << FRAC_BITS) - x * x, FRAC_BITS + 1);
        end else begin
          r = round_down_by(2 * logistic(x) - Q31, 31 - FRAC_BITS);
        end
      end
      MODE_ULOG: begin
        if (kind == KIND_DERIV) begin
          r = round_down_by(x * UNIT - x * x, FRAC_BITS);
        end else begin
          r = round_down_by(logistic(x), 31 - FRAC_BITS);
        end
      end
      MODE_BSTEP: begin
        if (kind == KIND_DERIV) begin
          r = (x == 0) ? NEAR_TWO : LEAK;
        end else begin
          r = (x < 0) ? -NEAR_ONE : ((x > 0) ? NEAR_ONE : 0);
        end
      end
      MODE_USTEP: begin
        if (kind == KIND_DERIV) begin
          r = (x == 0) ? NEAR_ONE : LEAK;
        end else begin
          r = (x < 0) ? LEAK : ((x > 0) ? NEAR_ONE : 0);
        end
      end
      default: begin
        r = (kind == KIND_DERIV) ? UNIT : x;
      end
    endcase
    res.saturated = 1'b0;
    if (r > VAL_MAX) begin
      r = VAL_MAX;
      res.saturated = 1'b1;
    end else if (r < VAL_MIN) begin
      r = VAL_MIN;
      res.saturated = 1'b1;
    end
    res.result = r[VALUE_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    afu_result_t want;
    if (!rst_ni) begin
      mode <= MODE_RAMP;
      expected_results.delete();
      mismatches = 0;
      outstanding_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      // the result always leaves after its input, so pop first
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with none expected: result %0d saturated %0b",
                 result_o, saturated_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (result_o !== want.result) begin
            $error("result mismatch: expected %0d, actual %0d", want.result, result_o);
            mismatches++;
          end
          if (saturated_o !== want.saturated) begin
            $error("saturated mismatch: expected %0b, actual %0b", want.saturated, saturated_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(activate(mode, kind_i, value_i));
      end
      if (psel && penable && pwrite && pready && paddr == MODE_ADDR) begin
        mode <= pwdata[MODE_W-1:0];
      end
      outstanding_o <= expected_results.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives the activation function unit through every mode, including the
// two spare mode codes, with directed edge operands and then random
// batches under four idle and stall phases and one long receiver hold-off;
// the checker beside the block predicts and compares, this module gives
// the verdict from its mismatch count
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import afu_pkg::*;

  localparam logic [APB_AW-1:0] MODE_ADDR     = {REG_ACT_MODE, 2'b00};
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int                N_BATCHES     = 10;
  localparam int                BATCH_ITEMS   = 110;

  localparam logic [MODE_W-1:0] MODE_LIST [8] = '{
    MODE_RAMP, MODE_RELU, MODE_BLOG, MODE_ULOG,
    MODE_BSTEP, MODE_USTEP, MODE_SPARE_LO, MODE_SPARE_HI
  };

  localparam logic signed [VALUE_W-1:0] EDGE_VALUES [10] = '{
    16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff,
    16'sh7fc0, 16'sh8040, 16'sh7fbf, 16'sh1000, 16'shf000
  };

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        psel        = 1'b0;
  logic                        penable     = 1'b0;
  logic                        pwrite      = 1'b0;
  logic [APB_AW-1:0]           paddr       = '0;
  logic [APB_DW-1:0]           pwdata      = '0;
  logic [APB_DW-1:0]           prdata;
  logic                        pready;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic                        kind_i      = KIND_ACT;
  logic signed [VALUE_W-1:0]   value_i     = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [VALUE_W-1:0]   result_o;
  logic                        saturated_o;

  int   outstanding;
  int   mismatch_count;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_off       = 1'b0;

  activation_function_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_o),
    .saturated_o (saturated_o)
  );

  afu_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_o         (result_o),
    .saturated_o      (saturated_o),
    .outstanding_o    (outstanding),
    .mismatch_count_o (mismatch_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_mode(input logic [MODE_W-1:0] m);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= MODE_ADDR;
    pwdata  <= APB_DW'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_item(input logic k, input logic signed [VALUE_W-1:0] v);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      kind_i     <= $urandom_range(1);
      value_i    <= $urandom;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(3))
      0:       return EDGE_VALUES[$urandom_range(9)];
      1:       return VALUE_W'(int'($urandom_range(8192)) - 4096);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic send_batch(input int n);
    repeat (n) begin
      send_item($urandom_range(1) ? KIND_DERIV : KIND_ACT, pick_value());
    end
  endtask

  // let every transaction in flight come out before touching the mode
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic hold_receiver(input int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_off <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 8; i++) begin
      write_mode(MODE_LIST[i]);
      send_item(KIND_ACT, 16'sh8000);
      send_item(KIND_DERIV, 16'sh7fff);
      send_item(i[0] ? KIND_ACT : KIND_DERIV, 16'sh0000);
      drain();
    end

    for (int b = 0; b < N_BATCHES; b++) begin
      case (b % 4)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 49;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 49;
        end
        default: begin
          send_idle_pct  <= 32;
          recv_stall_pct <= 32;
        end
      endcase
      write_mode((b < 6) ? MODE_LIST[b] : MODE_LIST[$urandom_range(7)]);
      if (b == 4) begin
        fork
          hold_receiver(80);
          send_batch(BATCH_ITEMS);
        join
      end else begin
        send_batch(BATCH_ITEMS);
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- activation_function_unit.f -----
+incdir+hw/rtl
hw/rtl/afu_pkg.sv
hw/rtl/afu_regs.sv
hw/rtl/afu_datapath.sv
hw/rtl/activation_function_unit.sv
hw/rtl/afu_checker.sv
dv/afu_checker.sv
dv/tb_top.sv
